// ===== hdl/pftb_pkg.sv =====
// Shared constants, codes and types for the page framebuffer tile blitter.
package pftb_pkg;

	localparam int SCREEN_W    = 128;
	localparam int SCREEN_H    = 64;
	localparam int STORE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int BYTE_W      = 8;
	localparam int TILE_W      = 8 * BYTE_W;
	localparam int FULL_ADDR_W = 16;

	localparam logic [1:0] ACT_DRAW   = 2'd0;
	localparam logic [1:0] ACT_MASKED = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;
	localparam logic [1:0] ACT_WRITE  = 2'd3;

	// Shift applied to tile and mask bytes for one page byte update.
	typedef struct packed {
		logic       shr;
		logic [2:0] amt;
	} shift_ctl_t;

endpackage

// ===== hdl/pftb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pftb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/pftb_blend.sv =====
// Shift-and-merge unit: one page byte read-modify-write step.
module pftb_blend
	import pftb_pkg::*;
(
	input  logic [BYTE_W-1:0] old_byte,
	input  logic [BYTE_W-1:0] tile_byte,
	input  logic [BYTE_W-1:0] mask_byte,
	input  shift_ctl_t        ctl,
	output logic [BYTE_W-1:0] new_byte
);

	logic [BYTE_W-1:0] t_sh;
	logic [BYTE_W-1:0] m_sh;
	logic [BYTE_W-1:0] keep;

	always_comb begin
		if (ctl.shr) begin
			t_sh = tile_byte >> ctl.amt;
			m_sh = mask_byte >> ctl.amt;
			keep = ~(8'hff >> ctl.amt);
		end else begin
			t_sh = tile_byte << ctl.amt;
			m_sh = mask_byte << ctl.amt;
			keep = ~(8'hff << ctl.amt);
		end
		// keep bits outside the tile, clear where mask is 0, then OR tile in
		new_byte = (old_byte & (m_sh | keep)) | t_sh;
	end

endmodule

// ===== hdl/page_framebuffer_tile_blitter_top.sv =====
// Top level of the page-mode framebuffer tile blitter with its sequencer.
//
// A 1024-byte monochrome framebuffer in page layout (byte at page*128+column,
// bit 0 the top row of the page), cleared after reset by a pass that writes
// one byte per cycle to every address; no item is accepted during that pass.
// For a draw item the sequencer walks 16 slots (eight columns, upper and
// lower page byte each), reading one byte per cycle and writing the merged
// byte in the following cycle through the single shared shift-and-merge
// unit, then passes a drain state before the next item is accepted; slots
// that are clipped off-screen are skipped but still walked. A fully
// off-screen tile is accepted without a walk. A byte write passes one write
// state; a byte read waits until the previous read result is taken.
module page_framebuffer_tile_blitter_top
	import pftb_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              action,
	input  logic [TILE_W-1:0]       tile_columns,
	input  logic [TILE_W-1:0]       mask_columns,
	input  logic signed [8:0]       x_position,
	input  logic signed [8:0]       y_position,
	input  logic [ADDR_W-1:0]       byte_address,
	input  logic [BYTE_W-1:0]       write_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [BYTE_W-1:0]       read_data
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DRAW  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;
	localparam logic [2:0] ST_RDATA = 3'd5;
	localparam logic [2:0] ST_WRITE = 3'd6;

	logic [2:0]              state_q;
	logic [ADDR_W-1:0]       clr_q;
	logic [3:0]              idx_q;
	logic signed [8:0]       x_q;
	logic signed [8:0]       y_q;
	logic [TILE_W-1:0]       tile_q;
	logic [TILE_W-1:0]       mask_q;
	logic [ADDR_W-1:0]       addr_q;
	logic [BYTE_W-1:0]       wdata_q;
	logic                    out_valid_q;
	logic [BYTE_W-1:0]       rd_q;

	logic                    op_valid_s1;
	logic [ADDR_W-1:0]       addr_s1;
	logic [BYTE_W-1:0]       t_s1;
	logic [BYTE_W-1:0]       m_s1;
	shift_ctl_t              ctl_s1;

	logic                    accept;
	logic                    on_screen;
	logic                    out_free;
	logic [9:0]              col_u;
	logic signed [9:0]       col;
	logic                    col_ok;
	logic [5:0]              pg;
	logic [FULL_ADDR_W-1:0]  full_addr;
	logic                    op_ok;
	shift_ctl_t              op_ctl;
	logic [BYTE_W-1:0]       op_t;
	logic [BYTE_W-1:0]       op_m;

	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr;
	logic [BYTE_W-1:0]       ram_wdata;
	logic [ADDR_W-1:0]       ram_raddr;
	logic [BYTE_W-1:0]       ram_rdata;
	logic [BYTE_W-1:0]       blend_out;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign read_data = rd_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign on_screen = !(int'(x_position) < -7 || int'(x_position) >= SCREEN_W ||
		int'(y_position) < -7 || int'(y_position) >= SCREEN_H);

	// Slot decode: column from idx[3:1], upper/lower page byte from idx[0]
	assign col_u  = {x_q[8], x_q} + {7'd0, idx_q[3:1]};
	assign col    = col_u;
	assign col_ok = !col[9] && (int'(col) < SCREEN_W);
	assign op_t   = tile_q[{idx_q[3:1], 3'b000} +: BYTE_W];
	assign op_m   = mask_q[{idx_q[3:1], 3'b000} +: BYTE_W];

	always_comb begin
		pg     = '0;
		op_ctl = '0;
		op_ok  = 1'b0;
		if (!y_q[8]) begin
			if (!idx_q[0]) begin
				pg         = {1'b0, y_q[7:3]};
				op_ctl.shr = 1'b0;
				op_ctl.amt = y_q[2:0];
				op_ok      = col_ok;
			end else begin
				pg         = {1'b0, y_q[7:3]} + 6'd1;
				op_ctl.shr = 1'b1;
				op_ctl.amt = 3'd0 - y_q[2:0];
				op_ok      = col_ok && (y_q[2:0] != 3'd0) && (int'(y_q) <= SCREEN_H - 8);
			end
		end else begin
			// above the top edge: page 0 only, shifted up
			op_ctl.shr = 1'b1;
			op_ctl.amt = 3'd0 - y_q[2:0];
			op_ok      = col_ok && !idx_q[0];
		end
		full_addr = FULL_ADDR_W'(pg) * FULL_ADDR_W'(SCREEN_W) +
			{{(FULL_ADDR_W - 9){1'b0}}, col[8:0]};
		// drop writes beyond the store
		op_ok = op_ok && (full_addr < FULL_ADDR_W'(STORE_DEPTH));
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = wdata_q;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == ST_WRITE) begin
			ram_we = 1'b1;
		end else if (op_valid_s1) begin
			ram_we    = 1'b1;
			ram_waddr = addr_s1;
			ram_wdata = blend_out;
		end
		ram_raddr = (state_q == ST_DRAW) ? full_addr[ADDR_W-1:0] : addr_q;
	end

	pftb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	pftb_blend u_blend (
		.old_byte (ram_rdata),
		.tile_byte(t_s1),
		.mask_byte(m_s1),
		.ctl      (ctl_s1),
		.new_byte (blend_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			op_valid_s1 <= 1'b0;
		end else begin
			op_valid_s1 <= (state_q == ST_DRAW) && op_ok;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (action)
							ACT_DRAW, ACT_MASKED: begin
								idx_q <= '0;
								if (on_screen) begin
									state_q <= ST_DRAW;
								end
							end
							ACT_READ:  state_q <= ST_READ;
							ACT_WRITE: state_q <= ST_WRITE;
							default:   state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DRAW: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == 4'd15) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_IDLE;
				ST_READ: begin
					// issue the read only once the result register will be free
					if (out_free) begin
						state_q <= ST_RDATA;
					end
				end
				ST_RDATA: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_WRITE: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= x_position;
			y_q     <= y_position;
			tile_q  <= tile_columns;
			mask_q  <= (action == ACT_MASKED) ? mask_columns : '1;
			addr_q  <= byte_address;
			wdata_q <= write_data;
		end
		if (state_q == ST_RDATA) begin
			rd_q <= ram_rdata;
		end
		addr_s1 <= full_addr[ADDR_W-1:0];
		t_s1    <= op_t;
		m_s1    <= op_m;
		ctl_s1  <= op_ctl;
	end

`ifndef SYNTH
	ap_s1_in_draw: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid_s1 |-> (state_q == ST_DRAW || state_q == ST_DRAIN))
		else $error("blend write outside a draw");

	ap_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_RDATA)
		else $error("result raised without a read");

	ap_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RDATA) |-> !out_valid_q)
		else $error("read result would overwrite a pending result");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the page framebuffer tile blitter.
`timescale 1ns / 100ps

module tb;
	import pftb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 40;
	localparam int RANDOM_ITEMS   = 750;
	localparam int CALM_ITEMS     = 100;

	typedef struct {
		logic [1:0]        act;
		logic [TILE_W-1:0] tile;
		logic [TILE_W-1:0] mask;
		logic signed [8:0] x;
		logic signed [8:0] y;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] wdata;
		bit                fixed;
		logic [BYTE_W-1:0] want;
	} blit_item_t;

	logic                    clk;
	logic                    arst_n       = 1'b0;
	logic                    in_valid     = 1'b0;
	logic                    in_stall;
	logic [1:0]              action       = ACT_READ;
	logic [TILE_W-1:0]       tile_columns = '0;
	logic [TILE_W-1:0]       mask_columns = '0;
	logic signed [8:0]       x_position   = '0;
	logic signed [8:0]       y_position   = '0;
	logic [ADDR_W-1:0]       byte_address = '0;
	logic [BYTE_W-1:0]       write_data   = '0;
	logic                    out_valid;
	logic                    out_stall    = 1'b0;
	logic [BYTE_W-1:0]       read_data;

	logic [BYTE_W-1:0] frame_img [STORE_DEPTH];
	logic [BYTE_W-1:0] read_bytes_due [$];
	int                mismatch_count = 0;
	int                idle_cycles    = 0;
	int                cycle_count    = 0;
	int                stall_left     = 0;
	int                items_sent     = 0;
	bit                calm           = 1'b0;
	int                last_x         = 0;
	int                last_y         = 0;

	page_framebuffer_tile_blitter_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.tile_columns (tile_columns),
		.mask_columns (mask_columns),
		.x_position   (x_position),
		.y_position   (y_position),
		.byte_address (byte_address),
		.write_data   (write_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_data    (read_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Keep bits set in keep, clear the rest where the mask is 0, then OR the tile in.
	function automatic void merge_page_byte(int addr, logic [7:0] keep, logic [7:0] m,
			logic [7:0] t);
		if (addr < 0 || addr >= STORE_DEPTH)
			return;
		frame_img[addr] = (frame_img[addr] & (m | keep)) | t;
	endfunction

	function automatic void blit_tile(logic [TILE_W-1:0] tile, logic [TILE_W-1:0] mask,
			bit masked, int x, int y);
		int         i;
		int         col;
		int         pg;
		int         sh;
		int         s2;
		logic [7:0] t;
		logic [7:0] m;
		if (x < -7 || x >= SCREEN_W || y < -7 || y >= SCREEN_H)
			return;
		for (i = 0; i < 8; i++) begin
			col = x + i;
			t = tile[8*i +: 8];
			m = masked ? mask[8*i +: 8] : 8'hff;
			if (col < 0 || col >= SCREEN_W)
				continue;
			if (y >= 0) begin
				pg = y >> 3;
				sh = y & 7;
				merge_page_byte(pg * SCREEN_W + col, 8'((1 << sh) - 1),
					8'(m << sh), 8'(t << sh));
				if (sh != 0 && y <= SCREEN_H - 8) begin
					s2 = 8 - sh;
					merge_page_byte((pg + 1) * SCREEN_W + col, ~(8'hff >> s2),
						m >> s2, t >> s2);
				end
			end else begin
				s2 = -y;
				merge_page_byte(col, ~(8'hff >> s2), m >> s2, t >> s2);
			end
		end
	endfunction

	function automatic void apply_item(blit_item_t c);
		case (c.act)
			ACT_DRAW:   blit_tile(c.tile, c.mask, 1'b0, int'(c.x), int'(c.y));
			ACT_MASKED: blit_tile(c.tile, c.mask, 1'b1, int'(c.x), int'(c.y));
			ACT_READ:   read_bytes_due.push_back(c.fixed ? c.want : frame_img[c.addr]);
			ACT_WRITE:  frame_img[c.addr] = c.wdata;
			default:    ;
		endcase
	endfunction

	function automatic blit_item_t mk(logic [1:0] act, logic [TILE_W-1:0] tile,
			logic [TILE_W-1:0] mask, int x, int y, int addr, logic [7:0] wdata,
			bit fixed = 1'b0, logic [7:0] want = 8'h00);
		blit_item_t c;
		c.act   = act;
		c.tile  = tile;
		c.mask  = mask;
		c.x     = x[8:0];
		c.y     = y[8:0];
		c.addr  = addr[ADDR_W-1:0];
		c.wdata = wdata;
		c.fixed = fixed;
		c.want  = want;
		return c;
	endfunction

	function automatic logic [TILE_W-1:0] rand_cols();
		logic [TILE_W-1:0] v;
		v = {$urandom, $urandom};
		// thin out some tiles so the screen does not saturate
		if ($urandom_range(2) == 0)
			v &= {$urandom, $urandom} & {$urandom, $urandom};
		return v;
	endfunction

	function automatic blit_item_t random_item();
		blit_item_t c;
		int         sel;
		int         pg;
		int         col;
		sel = $urandom_range(99);
		c = mk(ACT_READ, rand_cols(), {$urandom, $urandom}, 0, 0,
			$urandom_range(STORE_DEPTH - 1), 8'($urandom));
		if (sel < 45) begin
			c.act = ($urandom_range(1) == 0) ? ACT_DRAW : ACT_MASKED;
			if ($urandom_range(4) == 0) begin
				last_x = int'($urandom_range(511)) - 256;
				last_y = int'($urandom_range(511)) - 256;
			end else begin
				last_x = int'($urandom_range(SCREEN_W + 17)) - 9;
				last_y = int'($urandom_range(SCREEN_H + 17)) - 9;
			end
			c.x = last_x[8:0];
			c.y = last_y[8:0];
			if ($urandom_range(5) == 0)
				c.mask = ($urandom_range(1) == 0) ? '0 : '1;
		end else if (sel < 85) begin
			c.act = ACT_READ;
			// most reads look at the footprint of the latest tile
			if ($urandom_range(3) != 0) begin
				pg  = (last_y < 0 ? 0 : last_y >> 3) + int'($urandom_range(1));
				col = last_x + int'($urandom_range(7));
				pg  = pg > SCREEN_H / 8 - 1 ? SCREEN_H / 8 - 1 : pg;
				col = col < 0 ? 0 : (col > SCREEN_W - 1 ? SCREEN_W - 1 : col);
				c.addr = ADDR_W'(pg * SCREEN_W + col);
			end
			c.x = 9'($urandom);
			c.y = 9'($urandom);
		end else begin
			c.act = ACT_WRITE;
			if ($urandom_range(1) == 0)
				c.wdata = '0;
			c.x = 9'($urandom);
			c.y = 9'($urandom);
		end
		return c;
	endfunction

	task automatic push_item(input blit_item_t c);
		int gap;
		gap = 0;
		if (!calm && (items_sent / 40) % 3 != 2 && $urandom_range(3) == 0)
			gap = $urandom_range(1, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= c.act;
		tile_columns <= c.tile;
		mask_columns <= c.mask;
		x_position   <= c.x;
		y_position   <= c.y;
		byte_address <= c.addr;
		write_data   <= c.wdata;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		apply_item(c);
		items_sent++;
	endtask

	// receiver side: random stall bursts, with quiet stretches and a calm tail
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (calm || (cycle_count / 300) % 3 == 2) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(4) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(7);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		logic [BYTE_W-1:0] due;
		if (arst_n && out_valid && !out_stall) begin
			if (read_bytes_due.size() == 0) begin
				report_mismatch($sformatf("read_data %02h with no read pending", read_data));
			end else begin
				due = read_bytes_due.pop_front();
				if (read_data !== due)
					report_mismatch($sformatf("read_data got %02h want %02h", read_data, due));
			end
		end
	end

	// watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		blit_item_t plan [$];
		int         n;
		foreach (frame_img[k])
			frame_img[k] = '0;

		plan.push_back(mk(ACT_READ,   '1, '1, 255, -256, 0, 8'hff, 1'b1, 8'h00));
		plan.push_back(mk(ACT_READ,   '0, '0, -256, 255, STORE_DEPTH - 1, 8'h00, 1'b1, 8'h00));
		plan.push_back(mk(ACT_WRITE,  '1, '1, 3, 3, STORE_DEPTH - 1, 8'hff));
		plan.push_back(mk(ACT_READ,   '0, '0, 0, 0, STORE_DEPTH - 1, 8'h00, 1'b1, 8'hff));
		plan.push_back(mk(ACT_WRITE,  '0, '0, 0, 0, 5, 8'h5a));
		plan.push_back(mk(ACT_DRAW,   64'h81, '1, 5, 0, STORE_DEPTH - 1, 8'hff));
		plan.push_back(mk(ACT_READ,   '0, '0, 0, 0, 5, 8'h00, 1'b1, 8'hdb));
		plan.push_back(mk(ACT_MASKED, 64'h10, 64'hffff_ffff_ffff_ff0f, 5, 0, 0, 8'h00));
		plan.push_back(mk(ACT_READ,   '0, '0, 0, 0, 5, 8'h00, 1'b1, 8'h1b));
		// top-left corner: only the bottom row of column 0 lands on page 0
		plan.push_back(mk(ACT_DRAW,   '1, '0, -7, -7, 77, 8'h33));
		plan.push_back(mk(ACT_READ,   '0, '0, 0, 0, 0, 8'h00));
		// right clip with a split across pages 0 and 1
		plan.push_back(mk(ACT_DRAW,   '1, '0, 121, 3, 0, 8'h00));
		plan.push_back(mk(ACT_READ,   '0, '0, 0, 0, 127, 8'h00));
		plan.push_back(mk(ACT_READ,   '0, '0, 0, 0, SCREEN_W + 127, 8'h00));
		// bottom clip: lower page dropped
		plan.push_back(mk(ACT_MASKED, 64'h0123_4567_89ab_cdef, 64'hf0f0_f0f0_0f0f_0f0f,
			60, 57, 0, 8'h00));
		plan.push_back(mk(ACT_READ,   '0, '0, 0, 0, 7 * SCREEN_W + 60, 8'h00));
		// fully off-screen tiles, then a tile on the bottom page
		plan.push_back(mk(ACT_DRAW,   '1, '0, -8, 0, 0, 8'h00));
		plan.push_back(mk(ACT_DRAW,   '1, '0, SCREEN_W, 0, 0, 8'h00));
		plan.push_back(mk(ACT_DRAW,   '1, '0, 0, SCREEN_H, 0, 8'h00));
		plan.push_back(mk(ACT_DRAW,   '1, '0, 0, -8, 0, 8'h00));
		plan.push_back(mk(ACT_DRAW,   '1, '1, -256, 255, 0, 8'h00));
		plan.push_back(mk(ACT_MASKED, '1, '0, 255, -256, 0, 8'h00));
		plan.push_back(mk(ACT_DRAW,   '1, '0, 0, SCREEN_H - 8, 0, 8'h00));
		plan.push_back(mk(ACT_READ,   '0, '0, 0, 0, 7 * SCREEN_W, 8'h00));
		plan.push_back(mk(ACT_READ,   '1, '1, -1, -1, 0, 8'hff));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k])
			push_item(plan[k]);
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			push_item(random_item());
		end
		in_valid <= 1'b0;

		while (read_bytes_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/pftb_pkg.sv
hdl/pftb_ram.sv
hdl/pftb_blend.sv
hdl/page_framebuffer_tile_blitter_top.sv
tb/sv/tb.sv
